### sv/c6502_pkg.sv
// Shared types and constants for the 6502 execute unit.
package c6502_pkg;

  typedef enum logic [5:0] {
    CMD_ADC   = 6'd0,
    CMD_AND   = 6'd1,
    CMD_ASL_A = 6'd2,
    CMD_ASL_M = 6'd3,
    CMD_BCC   = 6'd4,
    CMD_BCS   = 6'd5,
    CMD_BEQ   = 6'd6,
    CMD_BIT   = 6'd7,
    CMD_BMI   = 6'd8,
    CMD_BNE   = 6'd9,
    CMD_BPL   = 6'd10,
    CMD_BRK   = 6'd11,
    CMD_BVC   = 6'd12,
    CMD_BVS   = 6'd13,
    CMD_CLC   = 6'd14,
    CMD_CLD   = 6'd15,
    CMD_CLI   = 6'd16,
    CMD_CLV   = 6'd17,
    CMD_CMP   = 6'd18,
    CMD_CPX   = 6'd19,
    CMD_CPY   = 6'd20,
    CMD_DEC   = 6'd21,
    CMD_DEX   = 6'd22,
    CMD_DEY   = 6'd23,
    CMD_EOR   = 6'd24,
    CMD_INC   = 6'd25,
    CMD_INX   = 6'd26,
    CMD_INY   = 6'd27,
    CMD_JMP   = 6'd28,
    CMD_JSR   = 6'd29,
    CMD_LDA   = 6'd30,
    CMD_LDX   = 6'd31,
    CMD_LDY   = 6'd32,
    CMD_LSR_A = 6'd33,
    CMD_LSR_M = 6'd34,
    CMD_NOP   = 6'd35,
    CMD_ORA   = 6'd36,
    CMD_PHA   = 6'd37,
    CMD_PHP   = 6'd38,
    CMD_PLA   = 6'd39,
    CMD_PLP   = 6'd40,
    CMD_ROL_A = 6'd41,
    CMD_ROL_M = 6'd42,
    CMD_ROR_A = 6'd43,
    CMD_ROR_M = 6'd44,
    CMD_RTI   = 6'd45,
    CMD_SEC   = 6'd46,
    CMD_SED   = 6'd47,
    CMD_SEI   = 6'd48,
    CMD_STA   = 6'd49,
    CMD_STX   = 6'd50,
    CMD_STY   = 6'd51,
    CMD_TAX   = 6'd52,
    CMD_TAY   = 6'd53,
    CMD_TSX   = 6'd54,
    CMD_TXA   = 6'd55,
    CMD_TXS   = 6'd56,
    CMD_TYA   = 6'd57
  } cmd_t;

  // Status bit positions, NV-BDIZC.
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_B = 4;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  localparam logic [7:0]  FLAGS_RESET = 8'h20;
  localparam logic [7:0]  SP_RESET    = 8'hFF;
  localparam logic [7:0]  RTI_MASK    = 8'hEF;

  // Stack is split into four banks by the low two address bits, so any three
  // consecutive stack bytes fall into different banks.
  localparam int STK_BANKS = 4;
  localparam int STK_DEPTH = 64;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  flags;
    logic [15:0] pc;
  } regs_t;

  // Bytes pushed by one operation: data[0] goes to sp, data[1] to sp-1, ...
  typedef struct packed {
    logic [1:0]      count;
    logic [2:0][7:0] data;
  } stk_push_t;

endpackage

### sv/c6502_ram.sv
// Generic single-write, single-read RAM with registered read data.
module c6502_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/c6502_stack.sv
// Banked stack store with valid bits, write forwarding and pull-byte select.
module c6502_stack (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,
  input  logic [7:0]            rd_sp,
  input  logic                  wr_en,
  input  logic [7:0]            sp,
  input  c6502_pkg::stk_push_t  push,
  output logic [2:0][7:0]       pull
);

  localparam int NB = c6502_pkg::STK_BANKS;
  localparam int AW = $clog2(c6502_pkg::STK_DEPTH);

  logic [7:0]             rd_base;
  logic [NB-1:0][AW-1:0]  ridx;
  logic [NB-1:0][AW-1:0]  widx;
  logic [NB-1:0][7:0]     wdata;
  logic [NB-1:0]          we;
  logic [NB-1:0][7:0]     ram_q;
  logic [NB-1:0][c6502_pkg::STK_DEPTH-1:0] vld;
  logic [NB-1:0]          vld_q;
  logic [NB-1:0]          byp;
  logic [NB-1:0][7:0]     byp_data;
  logic [NB-1:0][7:0]     bank_byte;
  logic [7:0]             pull_addr [3];

  assign rd_base = rd_sp + 8'd1;

  always_comb begin
    for (int b = 0; b < NB; b++) begin
      logic [1:0] k;
      logic [7:0] wa;
      // Reads cover rd_sp+1 .. rd_sp+4, one address per bank.
      if (2'(b) >= rd_base[1:0]) begin
        ridx[b] = rd_base[7:2];
      end else begin
        ridx[b] = rd_base[7:2] + 6'd1;
      end
      k = sp[1:0] - 2'(b);
      wa = sp - {6'd0, k};
      widx[b] = wa[7:2];
      wdata[b] = (k == 2'd3) ? 8'd0 : push.data[k];
      we[b] = wr_en && (k < push.count);
    end
  end

  for (genvar b = 0; b < NB; b++) begin : g_bank
    c6502_ram #(
      .WIDTH(8),
      .DEPTH(c6502_pkg::STK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we[b]),
      .waddr (widx[b]),
      .wdata (wdata[b]),
      .re    (rd_en),
      .raddr (ridx[b]),
      .rdata (ram_q[b])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[b] <= '0;
      end else if (we[b]) begin
        vld[b][widx[b]] <= 1'b1;
      end
    end

    // A write in the same cycle as the read is not seen by the RAM, so it is
    // captured here and used in place of the read data.
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[b] <= 1'b0;
        byp[b]   <= 1'b0;
      end else if (rd_en) begin
        vld_q[b] <= vld[b][ridx[b]];
        byp[b]   <= we[b] && (widx[b] == ridx[b]);
      end
    end

    always_ff @(posedge clk) begin
      if (rd_en) begin
        byp_data[b] <= wdata[b];
      end
    end

    assign bank_byte[b] = byp[b] ? byp_data[b] : (vld_q[b] ? ram_q[b] : 8'd0);
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pull_addr[j] = sp + 8'(j + 1);
      pull[j] = bank_byte[pull_addr[j][1:0]];
    end
  end

endmodule

### sv/c6502_alu.sv
// Combinational execute step: next register file, memory byte and stack pushes.
module c6502_alu (
  input  c6502_pkg::cmd_t       cmd,
  input  logic [7:0]            operand,
  input  logic [15:0]           target_address,
  input  logic [15:0]           break_vector,
  input  c6502_pkg::regs_t      cur,
  input  logic [2:0][7:0]       pull,
  output c6502_pkg::regs_t      nxt,
  output logic                  mem_write,
  output logic [7:0]            mem_data,
  output c6502_pkg::stk_push_t  push
);

  function automatic logic [7:0] set_nz(input logic [7:0] f, input logic [7:0] v);
    logic [7:0] r;
    r = f;
    r[c6502_pkg::FLAG_N] = v[7];
    r[c6502_pkg::FLAG_Z] = (v == 8'd0);
    return r;
  endfunction

  // Returns {carry, result}.
  function automatic logic [8:0] shift_byte(input logic left, input logic rot,
                                            input logic [7:0] v, input logic cin);
    logic fill;
    fill = rot & cin;
    if (left) begin
      return {v[7], v[6:0], fill};
    end else begin
      return {v[0], fill, v[7:1]};
    end
  endfunction

  logic [8:0]  sum;
  logic [7:0]  cmp_reg;
  logic [8:0]  diff;
  logic [15:0] br_target;
  logic        br_take;
  logic [15:0] pc_inc;
  logic [7:0]  sh_in;
  logic [8:0]  sh;
  logic        cin;

  assign cin = cur.flags[c6502_pkg::FLAG_C];
  assign sum = {1'b0, cur.acc} + {1'b0, operand} + {8'd0, cin};
  assign br_target = cur.pc + {{8{operand[7]}}, operand};
  assign pc_inc = cur.pc + 16'd1;

  always_comb begin
    case (cmd)
      c6502_pkg::CMD_CPX: cmp_reg = cur.x;
      c6502_pkg::CMD_CPY: cmp_reg = cur.y;
      default:            cmp_reg = cur.acc;
    endcase
  end
  assign diff = {1'b0, cmp_reg} - {1'b0, operand};

  always_comb begin
    case (cmd)
      c6502_pkg::CMD_BCC: br_take = !cur.flags[c6502_pkg::FLAG_C];
      c6502_pkg::CMD_BCS: br_take =  cur.flags[c6502_pkg::FLAG_C];
      c6502_pkg::CMD_BEQ: br_take =  cur.flags[c6502_pkg::FLAG_Z];
      c6502_pkg::CMD_BNE: br_take = !cur.flags[c6502_pkg::FLAG_Z];
      c6502_pkg::CMD_BMI: br_take =  cur.flags[c6502_pkg::FLAG_N];
      c6502_pkg::CMD_BPL: br_take = !cur.flags[c6502_pkg::FLAG_N];
      c6502_pkg::CMD_BVS: br_take =  cur.flags[c6502_pkg::FLAG_V];
      c6502_pkg::CMD_BVC: br_take = !cur.flags[c6502_pkg::FLAG_V];
      default:            br_take = 1'b0;
    endcase
  end

  // One shifter serves both the accumulator and the memory forms.
  always_comb begin
    case (cmd)
      c6502_pkg::CMD_ASL_A, c6502_pkg::CMD_LSR_A,
      c6502_pkg::CMD_ROL_A, c6502_pkg::CMD_ROR_A: sh_in = cur.acc;
      default:                                     sh_in = operand;
    endcase
  end

  always_comb begin
    case (cmd)
      c6502_pkg::CMD_ASL_A, c6502_pkg::CMD_ASL_M: sh = shift_byte(1'b1, 1'b0, sh_in, cin);
      c6502_pkg::CMD_ROL_A, c6502_pkg::CMD_ROL_M: sh = shift_byte(1'b1, 1'b1, sh_in, cin);
      c6502_pkg::CMD_ROR_A, c6502_pkg::CMD_ROR_M: sh = shift_byte(1'b0, 1'b1, sh_in, cin);
      default:                                     sh = shift_byte(1'b0, 1'b0, sh_in, cin);
    endcase
  end

  always_comb begin
    nxt        = cur;
    mem_write  = 1'b0;
    mem_data   = 8'd0;
    push.count = 2'd0;
    push.data  = '0;
    case (cmd)
      c6502_pkg::CMD_ADC: begin
        nxt.acc = sum[7:0];
        nxt.flags[c6502_pkg::FLAG_C] = sum[8];
        nxt.flags[c6502_pkg::FLAG_V] = ~(cur.acc[7] ^ operand[7]) & (cur.acc[7] ^ sum[7]);
        nxt.flags = set_nz(nxt.flags, sum[7:0]);
      end
      c6502_pkg::CMD_AND: begin
        nxt.acc = cur.acc & operand;
        nxt.flags = set_nz(cur.flags, cur.acc & operand);
      end
      c6502_pkg::CMD_EOR: begin
        nxt.acc = cur.acc ^ operand;
        nxt.flags = set_nz(cur.flags, cur.acc ^ operand);
      end
      c6502_pkg::CMD_ORA: begin
        nxt.acc = cur.acc | operand;
        nxt.flags = set_nz(cur.flags, cur.acc | operand);
      end
      c6502_pkg::CMD_ASL_A, c6502_pkg::CMD_LSR_A,
      c6502_pkg::CMD_ROL_A, c6502_pkg::CMD_ROR_A: begin
        nxt.acc = sh[7:0];
        nxt.flags[c6502_pkg::FLAG_C] = sh[8];
        nxt.flags = set_nz(nxt.flags, sh[7:0]);
      end
      c6502_pkg::CMD_ASL_M, c6502_pkg::CMD_LSR_M,
      c6502_pkg::CMD_ROL_M, c6502_pkg::CMD_ROR_M: begin
        mem_write = 1'b1;
        mem_data = sh[7:0];
        nxt.flags[c6502_pkg::FLAG_C] = sh[8];
        nxt.flags = set_nz(nxt.flags, sh[7:0]);
      end
      c6502_pkg::CMD_BCC, c6502_pkg::CMD_BCS, c6502_pkg::CMD_BEQ,
      c6502_pkg::CMD_BNE, c6502_pkg::CMD_BMI, c6502_pkg::CMD_BPL,
      c6502_pkg::CMD_BVC, c6502_pkg::CMD_BVS: begin
        if (br_take) begin
          nxt.pc = br_target;
        end
      end
      c6502_pkg::CMD_BIT: begin
        nxt.flags[c6502_pkg::FLAG_Z] = ((cur.acc & operand) == 8'd0);
        nxt.flags[c6502_pkg::FLAG_N] = operand[7];
        nxt.flags[c6502_pkg::FLAG_V] = operand[6];
      end
      c6502_pkg::CMD_BRK: begin
        push.count = 2'd3;
        push.data[0] = pc_inc[15:8];
        push.data[1] = pc_inc[7:0];
        push.data[2] = cur.flags | (8'd1 << c6502_pkg::FLAG_B);
        nxt.sp = cur.sp - 8'd3;
        nxt.flags[c6502_pkg::FLAG_I] = 1'b1;
        nxt.pc = break_vector;
      end
      c6502_pkg::CMD_CLC: nxt.flags[c6502_pkg::FLAG_C] = 1'b0;
      c6502_pkg::CMD_CLD: nxt.flags[c6502_pkg::FLAG_D] = 1'b0;
      c6502_pkg::CMD_CLI: nxt.flags[c6502_pkg::FLAG_I] = 1'b0;
      c6502_pkg::CMD_CLV: nxt.flags[c6502_pkg::FLAG_V] = 1'b0;
      c6502_pkg::CMD_SEC: nxt.flags[c6502_pkg::FLAG_C] = 1'b1;
      c6502_pkg::CMD_SED: nxt.flags[c6502_pkg::FLAG_D] = 1'b1;
      c6502_pkg::CMD_SEI: nxt.flags[c6502_pkg::FLAG_I] = 1'b1;
      c6502_pkg::CMD_CMP, c6502_pkg::CMD_CPX, c6502_pkg::CMD_CPY: begin
        nxt.flags = set_nz(cur.flags, diff[7:0]);
        nxt.flags[c6502_pkg::FLAG_C] = ~diff[8];
      end
      c6502_pkg::CMD_DEC: begin
        mem_write = 1'b1;
        mem_data = operand - 8'd1;
        nxt.flags = set_nz(cur.flags, operand - 8'd1);
      end
      c6502_pkg::CMD_INC: begin
        mem_write = 1'b1;
        mem_data = operand + 8'd1;
        nxt.flags = set_nz(cur.flags, operand + 8'd1);
      end
      c6502_pkg::CMD_DEX: begin
        nxt.x = cur.x - 8'd1;
        nxt.flags = set_nz(cur.flags, cur.x - 8'd1);
      end
      c6502_pkg::CMD_DEY: begin
        nxt.y = cur.y - 8'd1;
        nxt.flags = set_nz(cur.flags, cur.y - 8'd1);
      end
      c6502_pkg::CMD_INX: begin
        nxt.x = cur.x + 8'd1;
        nxt.flags = set_nz(cur.flags, cur.x + 8'd1);
      end
      c6502_pkg::CMD_INY: begin
        nxt.y = cur.y + 8'd1;
        nxt.flags = set_nz(cur.flags, cur.y + 8'd1);
      end
      c6502_pkg::CMD_JMP: nxt.pc = target_address;
      c6502_pkg::CMD_JSR: begin
        push.count = 2'd2;
        push.data[0] = cur.pc[15:8];
        push.data[1] = cur.pc[7:0];
        nxt.sp = cur.sp - 8'd2;
        nxt.pc = target_address;
      end
      c6502_pkg::CMD_LDA: begin
        nxt.acc = operand;
        nxt.flags = set_nz(cur.flags, operand);
      end
      c6502_pkg::CMD_LDX: begin
        nxt.x = operand;
        nxt.flags = set_nz(cur.flags, operand);
      end
      c6502_pkg::CMD_LDY: begin
        nxt.y = operand;
        nxt.flags = set_nz(cur.flags, operand);
      end
      c6502_pkg::CMD_PHA: begin
        push.count = 2'd1;
        push.data[0] = cur.acc;
        nxt.sp = cur.sp - 8'd1;
      end
      c6502_pkg::CMD_PHP: begin
        push.count = 2'd1;
        push.data[0] = cur.flags;
        nxt.sp = cur.sp - 8'd1;
      end
      // PLA leaves the flags alone in this unit.
      c6502_pkg::CMD_PLA: begin
        nxt.acc = pull[0];
        nxt.sp = cur.sp + 8'd1;
      end
      c6502_pkg::CMD_PLP: begin
        nxt.flags = pull[0];
        nxt.sp = cur.sp + 8'd1;
      end
      c6502_pkg::CMD_RTI: begin
        nxt.flags = pull[0] & c6502_pkg::RTI_MASK;
        nxt.pc = {pull[2], pull[1]};
        nxt.sp = cur.sp + 8'd3;
      end
      c6502_pkg::CMD_STA: begin
        mem_write = 1'b1;
        mem_data = cur.acc;
      end
      c6502_pkg::CMD_STX: begin
        mem_write = 1'b1;
        mem_data = cur.x;
      end
      c6502_pkg::CMD_STY: begin
        mem_write = 1'b1;
        mem_data = cur.y;
      end
      c6502_pkg::CMD_TAX: begin
        nxt.x = cur.acc;
        nxt.flags = set_nz(cur.flags, cur.acc);
      end
      c6502_pkg::CMD_TAY: begin
        nxt.y = cur.acc;
        nxt.flags = set_nz(cur.flags, cur.acc);
      end
      c6502_pkg::CMD_TSX: begin
        nxt.x = cur.sp;
        nxt.flags = set_nz(cur.flags, cur.sp);
      end
      c6502_pkg::CMD_TXA: begin
        nxt.acc = cur.x;
        nxt.flags = set_nz(cur.flags, cur.x);
      end
      c6502_pkg::CMD_TXS: nxt.sp = cur.x;
      c6502_pkg::CMD_TYA: begin
        nxt.acc = cur.y;
        nxt.flags = set_nz(cur.flags, cur.y);
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

### sv/cpu6502_execute_unit.sv
// Top level of the 6502 execute unit: stream handshake, register file and stack.
//
// Input words on s_tdata carry one decoded operation; output words on m_tdata
// carry the full register file after it, plus the memory byte to write back.
// A word accepted into the execute stage runs there (the stack banks are read
// as it is accepted), and its result is loaded into the output register when
// the execute stage fires. One word is taken and one retired every cycle while
// m_tready stays high, all operations alike; the stack banks give one read per
// bank and one write per bank each cycle, which covers BRK and RTI.
// The stack read for a new word is addressed from the stack pointer that the
// word ahead of it leaves, and a push in that same cycle is forwarded.
// A stalled m_tready holds the output register, then the execute stage, and
// s_tready falls only when both are full.
// Reset (rst, synchronous) clears A, X, Y and PC, sets SP to 0xFF, the status
// byte to 0x20 and break_vector to 0, and marks every stack byte as zero at
// once; words can be sent in the first cycle after reset. The user must have
// break_vector written via cfg_write_en/cfg_write_data while idle; not enforced.
module cpu6502_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // cmd[5:0], operand[13:6], target_address[29:14], zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // acc_out[7:0], x_out[15:8], y_out[23:16],
                                 // sp_out[31:24], flags_out[39:32], pc_out[55:40],
                                 // mem_write[56], mem_data[64:57], zero
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data
);

  c6502_pkg::regs_t      regs;
  c6502_pkg::regs_t      regs_next;
  logic [15:0]           break_vector;

  logic                  e_valid;
  c6502_pkg::cmd_t       e_cmd;
  logic [7:0]            e_operand;
  logic [15:0]           e_target;
  logic                  e_fire;
  logic                  accept;

  logic [2:0][7:0]       pull;
  c6502_pkg::stk_push_t  push;
  logic                  alu_mem_write;
  logic [7:0]            alu_mem_data;
  logic [7:0]            rd_sp;

  logic                  o_valid;
  c6502_pkg::regs_t      o_regs;
  logic                  o_mem_write;
  logic [7:0]            o_mem_data;

  assign e_fire   = e_valid && (!o_valid || m_tready);
  assign s_tready = !e_valid || e_fire;
  assign accept   = s_tvalid && s_tready;
  assign rd_sp    = e_valid ? regs_next.sp : regs.sp;

  always_ff @(posedge clk) begin
    if (rst) begin
      break_vector <= 16'd0;
    end else if (cfg_write_en) begin
      break_vector <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (accept) begin
      e_valid <= 1'b1;
    end else if (e_fire) begin
      e_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e_cmd     <= c6502_pkg::cmd_t'(s_tdata[5:0]);
      e_operand <= s_tdata[13:6];
      e_target  <= s_tdata[29:14];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.acc   <= 8'd0;
      regs.x     <= 8'd0;
      regs.y     <= 8'd0;
      regs.sp    <= c6502_pkg::SP_RESET;
      regs.flags <= c6502_pkg::FLAGS_RESET;
      regs.pc    <= 16'd0;
    end else if (e_fire) begin
      regs <= regs_next;
    end
  end

  c6502_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .rd_en (accept),
    .rd_sp (rd_sp),
    .wr_en (e_fire),
    .sp    (regs.sp),
    .push  (push),
    .pull  (pull)
  );

  c6502_alu u_alu (
    .cmd            (e_cmd),
    .operand        (e_operand),
    .target_address (e_target),
    .break_vector   (break_vector),
    .cur            (regs),
    .pull           (pull),
    .nxt            (regs_next),
    .mem_write      (alu_mem_write),
    .mem_data       (alu_mem_data),
    .push           (push)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (e_fire) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (e_fire) begin
      o_regs      <= regs_next;
      o_mem_write <= alu_mem_write;
      o_mem_data  <= alu_mem_data;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {7'd0, o_mem_data, o_mem_write, o_regs.pc, o_regs.flags,
                     o_regs.sp, o_regs.y, o_regs.x, o_regs.acc};

endmodule
